[hw/rtl/fcbm_pkg.sv]
// Shared types and constants of the freezer cartridge bus mapper.
`timescale 1ns / 1ps

package fcbm_pkg;

  // Store geometry
  localparam int ROM_DEPTH  = 32768;
  localparam int SIDE_DEPTH = 8192;
  localparam int ROM_AW     = $clog2(ROM_DEPTH);
  localparam int SIDE_AW    = $clog2(SIDE_DEPTH);
  localparam int BANK_AW    = ROM_AW - SIDE_AW;

  // Default number of ROM banks
  localparam int BANK_COUNT_DEF = 4;

  // Fixed byte values and offsets
  localparam logic [7:0]         RAM_FILL      = 8'hBD;
  localparam logic [7:0]         UPPER_MASK    = 8'hE7;
  localparam logic [7:0]         UPPER_MATCH   = 8'h22;
  localparam logic [SIDE_AW-1:0] IO2_BASE      = SIDE_AW'(31 * 256);
  localparam logic [19:0]        DEBOUNCE_INIT = 20'd500000;
  localparam logic [1:0]         RUN_FULL      = 2'd3;
  localparam logic [1:0]         MODE_ULTIMAX  = 2'd3;

  // Configuration register indexes
  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] CFG_RAM_UPPER = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_KERNEL    = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_DEBOUNCE  = 2'd2;

  // Operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_BUS         = 2'd0,
    OP_LOAD_ROM    = 2'd1,
    OP_LOAD_KERNEL = 2'd2,
    OP_RESET       = 2'd3
  } opcode_t;

  // Source of the byte driven onto the bus
  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_RAM,
    SRC_ROM,
    SRC_KERNEL,
    SRC_CTRL
  } src_t;

  // One input transaction, unpacked
  typedef struct packed {
    opcode_t     opcode;
    logic [14:0] address;
    logic        cpu_writes;
    logic [7:0]  data_in;
    logic        low_rom_select;
    logic        high_rom_select;
    logic        io1_select;
    logic        io2_select;
    logic        kernel_area;
    logic        freeze_button;
  } item_t;

  // Memory accesses and line levels decided for one transaction
  typedef struct packed {
    src_t               src;
    logic               ram_re;
    logic               ram_we;
    logic [SIDE_AW-1:0] ram_addr;
    logic               rom_re;
    logic [ROM_AW-1:0]  rom_raddr;
    logic               rom_we;
    logic [ROM_AW-1:0]  rom_waddr;
    logic               kern_re;
    logic               kern_we;
    logic [SIDE_AW-1:0] kern_addr;
    logic [7:0]         wdata;
    logic [7:0]         ctrl_byte;
    logic               game;
    logic               exrom;
    logic               nmi;
  } op_t;

endpackage

[hw/rtl/freezer_cartridge_bus_mapper.sv]
// Top level of the freezer cartridge bus mapper: stream ports, pipeline and stores.
`timescale 1ns / 1ps

// One transaction is taken every clock cycle unless the output stalls or the RAM
// fill is running. A result passes the input register, then the registered store
// read, then the result register before it can be taken.
// Stores are read and written in the middle stage, so a read sees every write
// of earlier transactions. After reset the cartridge RAM is filled with 0xBD,
// one byte a cycle until all 8192 bytes are written; s_tready stays low during that pass while
// configuration writes are taken as usual.

module freezer_cartridge_bus_mapper #(
  parameter int BANK_COUNT = fcbm_pkg::BANK_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration
  input  logic                        cfg_we,
  input  logic [fcbm_pkg::CFG_IW-1:0] cfg_index,
  input  logic [19:0]                 cfg_data,
  // Input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // address[14:0], cpu_writes[15], data_in[23:16], low_rom_select[24],
  // high_rom_select[25], io1_select[26], io2_select[27], kernel_area[28],
  // freeze_button[29], zero[31:30]
  input  logic [31:0]                 s_tdata,
  // opcode[1:0]
  input  logic [1:0]                  s_tuser,
  // Output stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // drive_bus[0], bus_data[8:1], game_line[9], exrom_line[10], nmi_line[11],
  // zero[15:12]
  output logic [15:0]                 m_tdata
);

  localparam int SAW = fcbm_pkg::SIDE_AW;

  fcbm_pkg::item_t in_item;
  fcbm_pkg::item_t s1_item;
  fcbm_pkg::op_t   op;
  logic            s1_valid;
  logic            s2_valid;
  fcbm_pkg::src_t  s2_src;
  logic [7:0]      s2_ctrl;
  logic            s2_game;
  logic            s2_exrom;
  logic            s2_nmi;
  logic            out_free;
  logic            s2_free;
  logic            step;
  logic            clearing;
  logic [SAW-1:0]  clr_count;
  logic [7:0]      ram_q;
  logic [7:0]      rom_q;
  logic [7:0]      kern_q;
  logic            ram_we;
  logic [SAW-1:0]  ram_waddr;
  logic [7:0]      ram_wdata;
  logic [7:0]      bus_byte;

  // Unpack the input transaction
  always_comb begin
    in_item.opcode          = fcbm_pkg::opcode_t'(s_tuser);
    in_item.address         = s_tdata[14:0];
    in_item.cpu_writes      = s_tdata[15];
    in_item.data_in         = s_tdata[23:16];
    in_item.low_rom_select  = s_tdata[24];
    in_item.high_rom_select = s_tdata[25];
    in_item.io1_select      = s_tdata[26];
    in_item.io2_select      = s_tdata[27];
    in_item.kernel_area     = s_tdata[28];
    in_item.freeze_button   = s_tdata[29];
  end

  // Stage handshakes
  assign out_free = ~m_tvalid | m_tready;
  assign s2_free  = ~s2_valid | out_free;
  assign step     = s1_valid & s2_free;
  assign s_tready = ~clearing & (~s1_valid | step);

  // RAM fill pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_count <= '0;
    end else if (clearing) begin
      clr_count <= clr_count + SAW'(1);
      if (clr_count == {SAW{1'b1}}) clearing <= 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) s1_item <= in_item;
  end

  fcbm_ctrl #(
    .BANK_COUNT(BANK_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .item     (s1_item),
    .step     (step),
    .op       (op)
  );

  // RAM write port shared with the fill pass
  assign ram_we    = clearing | (step & op.ram_we);
  assign ram_waddr = clearing ? clr_count : op.ram_addr;
  assign ram_wdata = clearing ? fcbm_pkg::RAM_FILL : op.wdata;

  fcbm_ram #(
    .WIDTH(8),
    .DEPTH(fcbm_pkg::SIDE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (step & op.ram_re),
    .raddr(op.ram_addr),
    .rdata(ram_q)
  );

  fcbm_ram #(
    .WIDTH(8),
    .DEPTH(fcbm_pkg::ROM_DEPTH)
  ) u_rom (
    .clk  (clk),
    .we   (step & op.rom_we),
    .waddr(op.rom_waddr),
    .wdata(op.wdata),
    .re   (step & op.rom_re),
    .raddr(op.rom_raddr),
    .rdata(rom_q)
  );

  fcbm_ram #(
    .WIDTH(8),
    .DEPTH(fcbm_pkg::SIDE_DEPTH)
  ) u_kernel (
    .clk  (clk),
    .we   (step & op.kern_we),
    .waddr(op.kern_addr),
    .wdata(op.wdata),
    .re   (step & op.kern_re),
    .raddr(op.kern_addr),
    .rdata(kern_q)
  );

  // Store read stage: hold the decision beside the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_src   <= fcbm_pkg::SRC_NONE;
    end else if (s2_free) begin
      s2_valid <= step;
      if (step) s2_src <= op.src;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s2_ctrl  <= op.ctrl_byte;
      s2_game  <= op.game;
      s2_exrom <= op.exrom;
      s2_nmi   <= op.nmi;
    end
  end

  // Select the driven byte
  always_comb begin
    case (s2_src)
      fcbm_pkg::SRC_RAM:    bus_byte = ram_q;
      fcbm_pkg::SRC_ROM:    bus_byte = rom_q;
      fcbm_pkg::SRC_KERNEL: bus_byte = kern_q;
      fcbm_pkg::SRC_CTRL:   bus_byte = s2_ctrl;
      default:              bus_byte = 8'h00;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid) begin
      m_tdata <= {4'b0000, s2_nmi, s2_exrom, s2_game, bus_byte,
                  s2_src != fcbm_pkg::SRC_NONE};
    end
  end

  // No transaction enters while the RAM is being filled
  a_no_accept_in_fill: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("input accepted during RAM fill");

  // A blocked read stage keeps its transaction
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && m_tvalid && !m_tready) |=> s2_valid && $stable(s2_src))
    else $error("read stage lost a transaction while blocked");

  // The store stage only advances into a free or draining slot
  a_step_room: assert property (@(posedge clk) disable iff (rst)
    step |-> (!s2_valid || !m_tvalid || m_tready))
    else $error("decode advanced into a full read stage");

endmodule

[hw/rtl/fcbm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fcbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/fcbm_ctrl.sv]
// Bank and mode state, configuration registers and per-transaction decode.
`timescale 1ns / 1ps

module fcbm_ctrl #(
  parameter int BANK_COUNT = fcbm_pkg::BANK_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fcbm_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [19:0]                   cfg_data,
  input  fcbm_pkg::item_t               item,
  input  logic                          step,
  output fcbm_pkg::op_t                 op
);

  localparam int SAW = fcbm_pkg::SIDE_AW;
  localparam int BAW = fcbm_pkg::BANK_AW;

  // Bank number folded into the bank count
  localparam logic [BAW-1:0] BankMod0 = BAW'(0 % BANK_COUNT);
  localparam logic [BAW-1:0] BankMod1 = BAW'(1 % BANK_COUNT);
  localparam logic [BAW-1:0] BankMod2 = BAW'(2 % BANK_COUNT);
  localparam logic [BAW-1:0] BankMod3 = BAW'(3 % BANK_COUNT);

  // Configuration
  logic        ram_at_upper_variant;
  logic        kernel_present;
  logic [19:0] debounce_cycles;

  // Mapper state
  logic [7:0]     control_byte, control_byte_next;
  logic [BAW-1:0] bank_select, bank_select_next;
  logic           ram_low_export, ram_low_export_next;
  logic           ram_high_export, ram_high_export_next;
  logic           cart_enabled, cart_enabled_next;
  logic           mode3_flag, mode3_flag_next;
  logic           game_level, game_level_next;
  logic           exrom_level, exrom_level_next;
  logic           nmi_level, nmi_level_next;
  logic [1:0]     write_run, write_run_next;
  logic           freeze_pending, freeze_pending_next;
  logic [19:0]    button_holdoff, button_holdoff_next;

  logic [SAW-1:0] addr_win;
  logic [SAW-1:0] addr_io2;
  logic [BAW-1:0] bank_eff;
  logic           wr;
  logic           rd;
  logic           any_ram;
  logic           handled;
  logic           ctrl_wr;
  logic [7:0]     ctrl_val;
  logic [1:0]     mode_sel;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_at_upper_variant <= 1'b0;
      kernel_present       <= 1'b0;
      debounce_cycles      <= fcbm_pkg::DEBOUNCE_INIT;
    end else if (cfg_we) begin
      case (cfg_index)
        fcbm_pkg::CFG_RAM_UPPER: ram_at_upper_variant <= cfg_data[0];
        fcbm_pkg::CFG_KERNEL:    kernel_present       <= cfg_data[0];
        fcbm_pkg::CFG_DEBOUNCE:  debounce_cycles      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Fold the bank number
  always_comb begin
    case (bank_select)
      2'd0:    bank_eff = BankMod0;
      2'd1:    bank_eff = BankMod1;
      2'd2:    bank_eff = BankMod2;
      default: bank_eff = BankMod3;
    endcase
  end

  assign addr_win = item.address[SAW-1:0];
  assign addr_io2 = fcbm_pkg::IO2_BASE | SAW'(item.address[7:0]);
  assign wr       = item.cpu_writes;
  assign rd       = ~item.cpu_writes;
  assign any_ram  = ram_low_export | ram_high_export;

  // Decode one transaction and work out the next state
  always_comb begin
    control_byte_next    = control_byte;
    bank_select_next     = bank_select;
    ram_low_export_next  = ram_low_export;
    ram_high_export_next = ram_high_export;
    cart_enabled_next    = cart_enabled;
    mode3_flag_next      = mode3_flag;
    game_level_next      = game_level;
    exrom_level_next     = exrom_level;
    nmi_level_next       = nmi_level;
    write_run_next       = write_run;
    freeze_pending_next  = freeze_pending;
    button_holdoff_next  = button_holdoff;
    handled              = 1'b0;
    ctrl_wr              = 1'b0;
    ctrl_val             = item.data_in;
    mode_sel             = 2'd0;

    op           = '0;
    op.src       = fcbm_pkg::SRC_NONE;
    op.wdata     = item.data_in;
    op.ctrl_byte = control_byte;
    op.kern_addr = addr_win;
    op.ram_addr  = addr_win;
    op.rom_raddr = {bank_eff, addr_win};
    op.rom_waddr = item.address;

    case (item.opcode)
      fcbm_pkg::OP_LOAD_ROM: begin
        op.rom_we = 1'b1;
      end
      fcbm_pkg::OP_LOAD_KERNEL: begin
        op.kern_we = 1'b1;
      end
      fcbm_pkg::OP_RESET: begin
        cart_enabled_next   = 1'b1;
        ctrl_wr             = 1'b1;
        ctrl_val            = 8'h00;
        write_run_next      = 2'd0;
        freeze_pending_next = 1'b0;
        button_holdoff_next = 20'd0;
      end
      default: begin
        // Count consecutive writes, saturating
        if (wr) begin
          if (write_run != fcbm_pkg::RUN_FULL) write_run_next = write_run + 2'd1;
        end else begin
          write_run_next = 2'd0;
        end

        if (kernel_present && item.high_rom_select && item.kernel_area && !mode3_flag) begin
          op.src     = fcbm_pkg::SRC_KERNEL;
          op.kern_re = 1'b1;
          handled    = 1'b1;
        end else if (cart_enabled) begin
          handled = 1'b1;
          if (rd && ((item.high_rom_select && ram_high_export) ||
                     (item.low_rom_select && ram_low_export))) begin
            op.src    = fcbm_pkg::SRC_RAM;
            op.ram_re = 1'b1;
          end else if (rd && ((item.low_rom_select && !ram_low_export) ||
                              (item.high_rom_select && !ram_high_export))) begin
            op.src    = fcbm_pkg::SRC_ROM;
            op.rom_re = 1'b1;
          end else if (wr && ((item.low_rom_select && ram_low_export) ||
                              (item.high_rom_select && ram_high_export))) begin
            op.ram_we = 1'b1;
          end else if (rd && item.io1_select) begin
            op.src = fcbm_pkg::SRC_CTRL;
          end else if (rd && item.io2_select) begin
            op.ram_addr  = addr_io2;
            op.rom_raddr = {bank_eff, addr_io2};
            if (any_ram) begin
              op.src    = fcbm_pkg::SRC_RAM;
              op.ram_re = 1'b1;
            end else begin
              op.src    = fcbm_pkg::SRC_ROM;
              op.rom_re = 1'b1;
            end
          end else if (wr && item.io1_select) begin
            ctrl_wr = 1'b1;
          end else if (wr && item.io2_select && any_ram) begin
            op.ram_addr = addr_io2;
            op.ram_we   = 1'b1;
          end else begin
            handled = 1'b0;
          end
        end

        // Freeze button and entry into the freeze map
        if (!handled) begin
          if (item.freeze_button && button_holdoff == 20'd0) begin
            button_holdoff_next = debounce_cycles;
            freeze_pending_next = 1'b1;
            nmi_level_next      = 1'b0;
          end else begin
            if (button_holdoff != 20'd0) button_holdoff_next = button_holdoff - 20'd1;
            if (freeze_pending && write_run_next == fcbm_pkg::RUN_FULL) begin
              exrom_level_next     = 1'b1;
              nmi_level_next       = 1'b1;
              game_level_next      = 1'b0;
              cart_enabled_next    = 1'b1;
              mode3_flag_next      = 1'b1;
              freeze_pending_next  = 1'b0;
              bank_select_next     = '0;
              ram_high_export_next = 1'b0;
              ram_low_export_next  = ram_at_upper_variant;
            end
          end
        end
      end
    endcase

    // Apply a control register write
    if (ctrl_wr) begin
      control_byte_next = ctrl_val;
      bank_select_next  = ctrl_val[4:3];
      if (ctrl_val[2]) cart_enabled_next = 1'b0;
      if (ctrl_val[6]) nmi_level_next = 1'b1;
      if (ram_at_upper_variant &&
          (ctrl_val & fcbm_pkg::UPPER_MASK) == fcbm_pkg::UPPER_MATCH) begin
        ram_low_export_next  = 1'b0;
        ram_high_export_next = 1'b1;
        mode_sel             = 2'b01;
      end else begin
        ram_low_export_next  = ctrl_val[5];
        ram_high_export_next = 1'b0;
        mode_sel             = ctrl_val[1:0];
      end
      exrom_level_next = mode_sel[1];
      game_level_next  = ~mode_sel[0];
      mode3_flag_next  = (mode_sel == fcbm_pkg::MODE_ULTIMAX) & cart_enabled_next;
    end

    op.game  = game_level_next;
    op.exrom = exrom_level_next;
    op.nmi   = nmi_level_next;
  end

  // Commit state when the transaction moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      control_byte    <= 8'h00;
      bank_select     <= '0;
      ram_low_export  <= 1'b0;
      ram_high_export <= 1'b0;
      cart_enabled    <= 1'b1;
      mode3_flag      <= 1'b0;
      game_level      <= 1'b1;
      exrom_level     <= 1'b0;
      nmi_level       <= 1'b1;
      write_run       <= 2'd0;
      freeze_pending  <= 1'b0;
      button_holdoff  <= 20'd0;
    end else if (step) begin
      control_byte    <= control_byte_next;
      bank_select     <= bank_select_next;
      ram_low_export  <= ram_low_export_next;
      ram_high_export <= ram_high_export_next;
      cart_enabled    <= cart_enabled_next;
      mode3_flag      <= mode3_flag_next;
      game_level      <= game_level_next;
      exrom_level     <= exrom_level_next;
      nmi_level       <= nmi_level_next;
      write_run       <= write_run_next;
      freeze_pending  <= freeze_pending_next;
      button_holdoff  <= button_holdoff_next;
    end
  end

  // The freeze map only exists with the cartridge enabled
  a_mode3_enabled: assert property (@(posedge clk) disable iff (rst)
    mode3_flag |-> cart_enabled)
    else $error("mode 3 map active with cartridge disabled");

  // RAM is exported at one window at most
  a_one_ram_window: assert property (@(posedge clk) disable iff (rst)
    !(ram_low_export && ram_high_export))
    else $error("RAM exported at both windows");

endmodule

[dv/tb_freezer_cartridge_bus_mapper.sv]
// Self-checking testbench of the freezer cartridge bus mapper.
`timescale 1ns / 1ps

module tb_freezer_cartridge_bus_mapper;
  import fcbm_pkg::*;

  localparam int LIMIT   = 300000;
  localparam int LAT_PAD = 8;
  localparam int WINDOW  = 8192;

  // Strobe and button bits as packed into s_tdata[29:24]
  localparam bit [5:0] SEL_ROML = 6'b000001;
  localparam bit [5:0] SEL_ROMH = 6'b000010;
  localparam bit [5:0] SEL_IO1  = 6'b000100;
  localparam bit [5:0] SEL_IO2  = 6'b001000;
  localparam bit [5:0] SEL_KERN = 6'b010000;
  localparam bit [5:0] SEL_BTN  = 6'b100000;

  // One reply of the bus mapper
  typedef struct packed {
    bit       drive;
    bit [7:0] data;
    bit       game;
    bit       exrom;
    bit       nmi;
  } reply_t;

  localparam reply_t QUIET_LINES = {1'b0, 8'h00, 1'b1, 1'b0, 1'b1};

  // Cartridge register state
  typedef struct packed {
    bit [7:0]  ctrl;
    bit [1:0]  bank;
    bit        ram_lo;
    bit        ram_hi;
    bit        enabled;
    bit        ultimax;
    bit        game;
    bit        exrom;
    bit        nmi;
    bit [1:0]  wr_run;
    bit        frz_pend;
    bit [19:0] holdoff;
  } cart_t;

  // Directed stimulus row: transaction, whether the reply is typed in, the reply
  typedef struct packed {
    item_t  it;
    bit     typed;
    reply_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [19:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  freezer_cartridge_bus_mapper u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Mirror of the cartridge: registers, settings and the three stores
  cart_t     cart;
  bit        set_ram_upper;
  bit        set_kernel;
  bit [19:0] set_debounce;
  bit [7:0]  rom_mem  [ROM_DEPTH];
  bit        rom_ok   [ROM_DEPTH];
  bit [7:0]  kern_mem [SIDE_DEPTH];
  bit        kern_ok  [SIDE_DEPTH];
  bit [7:0]  ram_mem  [SIDE_DEPTH];

  // Store entry a trial prediction would read before it was ever loaded
  bit        rom_miss;
  bit        kern_miss;
  bit [14:0] rom_miss_idx;
  bit [12:0] kern_miss_idx;

  reply_t bus_replies_q [$];
  item_t  plan_q [$];
  row_t   dir_rows [$];
  int     n_sent = 0;
  int     n_fail = 0;
  int     cycles = 0;
  int     snd_idle = 0;
  int     rcv_idle = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  function automatic item_t mk(opcode_t op, bit [14:0] addr, bit wr, bit [7:0] d,
                               bit [5:0] sel);
    item_t it;
    it.opcode          = op;
    it.address         = addr;
    it.cpu_writes      = wr;
    it.data_in         = d;
    it.low_rom_select  = sel[0];
    it.high_rom_select = sel[1];
    it.io1_select      = sel[2];
    it.io2_select      = sel[3];
    it.kernel_area     = sel[4];
    it.freeze_button   = sel[5];
    return it;
  endfunction

  function automatic bit [14:0] rom_at(bit [1:0] bank, bit [12:0] off);
    int b;
    b = bank % BANK_COUNT_DEF;
    return 15'(b * WINDOW + off);
  endfunction

  function automatic bit [7:0] rom_byte(bit [14:0] i);
    if (!rom_ok[i]) begin
      rom_miss     = 1'b1;
      rom_miss_idx = i;
    end
    return rom_mem[i];
  endfunction

  function automatic bit [7:0] kern_byte(bit [12:0] i);
    if (!kern_ok[i]) begin
      kern_miss     = 1'b1;
      kern_miss_idx = i;
    end
    return kern_mem[i];
  endfunction

  // Mode lines from the two low bits of a control value
  function automatic cart_t with_lines(cart_t s, bit [1:0] f);
    s.exrom   = f[1];
    s.game    = !f[0];
    s.ultimax = (f == MODE_ULTIMAX) ? s.enabled : 1'b0;
    return s;
  endfunction

  // Apply a write of the control register
  function automatic cart_t with_ctrl(cart_t s, bit [7:0] v);
    s.ctrl = v;
    s.bank = v[4:3];
    if (v[2]) begin
      s.enabled = 1'b0;
      s.ultimax = 1'b0;
    end
    if (v[6]) s.nmi = 1'b1;
    if (set_ram_upper && (v & UPPER_MASK) == UPPER_MATCH) begin
      s.ram_lo = 1'b0;
      s.ram_hi = 1'b1;
      s = with_lines(s, 2'd1);
    end else begin
      s.ram_lo = v[5];
      s.ram_hi = 1'b0;
      s = with_lines(s, v[1:0]);
    end
    return s;
  endfunction

  // Predict the reply of one transaction; update the mirror only when commit is set
  function automatic reply_t map_bus_cycle(item_t it, bit commit);
    cart_t     s;
    reply_t    r;
    bit        wr;
    bit        roml;
    bit        romh;
    bit        anyram;
    bit [12:0] a;
    bit [12:0] a2;
    s         = cart;
    r         = '0;
    rom_miss  = 1'b0;
    kern_miss = 1'b0;
    wr        = it.cpu_writes;
    roml      = it.low_rom_select;
    romh      = it.high_rom_select;
    a         = it.address[12:0];
    a2        = IO2_BASE | {5'b0, it.address[7:0]};
    case (it.opcode)
      OP_LOAD_ROM: begin
        if (commit) begin
          rom_mem[it.address] = it.data_in;
          rom_ok[it.address]  = 1'b1;
        end
      end
      OP_LOAD_KERNEL: begin
        if (commit) begin
          kern_mem[a] = it.data_in;
          kern_ok[a]  = 1'b1;
        end
      end
      OP_RESET: begin
        s.enabled  = 1'b1;
        s          = with_ctrl(s, 8'h00);
        s.wr_run   = '0;
        s.frz_pend = 1'b0;
        s.holdoff  = '0;
      end
      default: begin
        if (wr) begin
          if (s.wr_run != RUN_FULL) s.wr_run = s.wr_run + 2'd1;
        end else begin
          s.wr_run = '0;
        end
        anyram = s.ram_lo | s.ram_hi;
        // Kernel replacement wins over everything, even on a write
        if (set_kernel && romh && it.kernel_area && !s.ultimax) begin
          r.drive = 1'b1;
          r.data  = kern_byte(a);
        end else if (s.enabled && !wr && ((romh && s.ram_hi) || (roml && s.ram_lo))) begin
          r.drive = 1'b1;
          r.data  = ram_mem[a];
        end else if (s.enabled && !wr && ((roml && !s.ram_lo) || (romh && !s.ram_hi))) begin
          r.drive = 1'b1;
          r.data  = rom_byte(rom_at(s.bank, a));
        end else if (s.enabled && wr && ((roml && s.ram_lo) || (romh && s.ram_hi))) begin
          if (commit) ram_mem[a] = it.data_in;
        end else if (s.enabled && !wr && it.io1_select) begin
          r.drive = 1'b1;
          r.data  = s.ctrl;
        end else if (s.enabled && !wr && it.io2_select) begin
          r.drive = 1'b1;
          r.data  = anyram ? ram_mem[a2] : rom_byte(rom_at(s.bank, a2));
        end else if (s.enabled && wr && it.io1_select) begin
          s = with_ctrl(s, it.data_in);
        end else if (s.enabled && wr && it.io2_select && anyram) begin
          if (commit) ram_mem[a2] = it.data_in;
        end else if (it.freeze_button && s.holdoff == '0) begin
          s.holdoff  = set_debounce;
          s.frz_pend = 1'b1;
          s.nmi      = 1'b0;
        end else begin
          if (s.holdoff != '0) s.holdoff = s.holdoff - 20'd1;
          // Stack push after the freeze NMI: enter the ultimax map
          if (s.frz_pend && s.wr_run == RUN_FULL) begin
            s.exrom    = 1'b1;
            s.nmi      = 1'b1;
            s.game     = 1'b0;
            s.enabled  = 1'b1;
            s.ultimax  = 1'b1;
            s.frz_pend = 1'b0;
            s.bank     = '0;
            s.ram_hi   = 1'b0;
            s.ram_lo   = set_ram_upper;
          end
        end
      end
    endcase
    r.game  = s.game;
    r.exrom = s.exrom;
    r.nmi   = s.nmi;
    if (commit) cart = s;
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_fail++;
    end
  endfunction

  // Take replies and compare against the oldest prediction; stall at random
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.drive = m_tdata[0];
      got.data  = m_tdata[8:1];
      got.game  = m_tdata[9];
      got.exrom = m_tdata[10];
      got.nmi   = m_tdata[11];
      if (bus_replies_q.size() == 0) begin
        $error("reply 0x%0h with no transaction pending", m_tdata);
        n_fail++;
      end else begin
        want = bus_replies_q.pop_front();
        check_field("drive_bus", int'(want.drive), int'(got.drive));
        check_field("bus_data", int'(want.data), int'(got.data));
        check_field("game_line", int'(want.game), int'(got.game));
        check_field("exrom_line", int'(want.exrom), int'(got.exrom));
        check_field("nmi_line", int'(want.nmi), int'(got.nmi));
      end
    end
    m_tready <= ($urandom_range(99) >= rcv_idle);
  end

  // Write all three registers back to back
  task automatic set_regs(bit up, bit kern, bit [19:0] deb);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RAM_UPPER;
    cfg_data  <= 20'(up);
    @(posedge clk);
    cfg_index <= CFG_KERNEL;
    cfg_data  <= 20'(kern);
    @(posedge clk);
    cfg_index <= CFG_DEBOUNCE;
    cfg_data  <= deb;
    @(posedge clk);
    cfg_we        <= 1'b0;
    set_ram_upper = up;
    set_kernel    = kern;
    set_debounce  = deb;
  endtask

  // Drive one transaction and record its reply once accepted
  task automatic send(item_t it, bit typed, reply_t want);
    reply_t pred;
    while ($urandom_range(99) < snd_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.opcode;
    s_tdata  <= {2'b00, it.freeze_button, it.kernel_area, it.io2_select, it.io1_select,
                 it.high_rom_select, it.low_rom_select, it.data_in, it.cpu_writes,
                 it.address};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = map_bus_cycle(it, 1'b1);
    bus_replies_q.push_back(typed ? want : pred);
    n_sent++;
  endtask

  // Load any ROM or kernel byte the transaction would read before it is sent
  task automatic issue(item_t it, bit typed, reply_t want);
    item_t    ld;
    bit [1:0] top;
    void'(map_bus_cycle(it, 1'b0));
    if (rom_miss || kern_miss) begin
      top        = 2'($urandom_range(3));
      ld         = item_t'(30'($urandom()));
      ld.opcode  = rom_miss ? OP_LOAD_ROM : OP_LOAD_KERNEL;
      ld.address = rom_miss ? rom_miss_idx : {top, kern_miss_idx};
      send(ld, 1'b0, '0);
    end
    send(it, typed, want);
  endtask

  // Hold the sender until every reply is in, then let the pipeline settle
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (bus_replies_q.size() != 0) @(posedge clk);
    repeat (LAT_PAD) @(posedge clk);
  endtask

  function automatic bit [5:0] window_sel();
    bit [5:0] sel;
    sel = 6'b1 << $urandom_range(4);
    if ($urandom_range(1)) sel = sel | SEL_KERN;
    return sel;
  endfunction

  // Queue one short bus sequence of a random kind
  task automatic plan_more();
    int       k;
    bit [7:0] v;
    bit [5:0] sel;
    k = $urandom_range(99);
    if (k < 25) begin
      // Freeze: button press, three pushes, then a read
      plan_q.push_back(mk(OP_BUS, 15'($urandom_range(32767)), 1'b0, 8'($urandom_range(255)),
                          SEL_BTN));
      repeat (3) begin
        sel = ($urandom_range(2) == 0) ? window_sel() & (SEL_ROML | SEL_ROMH) : 6'b0;
        plan_q.push_back(mk(OP_BUS, 15'($urandom_range(32767)), 1'b1,
                            8'($urandom_range(255)), sel));
      end
      plan_q.push_back(mk(OP_BUS, 15'($urandom_range(32767)), 1'b0, 8'($urandom_range(255)),
                          window_sel()));
    end else if (k < 45) begin
      // Control write followed by a few reads
      case ($urandom_range(2))
        0:       v = UPPER_MATCH | {3'b0, 2'($urandom_range(3)), 3'b0};
        1:       v = 8'($urandom_range(255)) & ~8'h04;
        default: v = 8'($urandom_range(255));
      endcase
      plan_q.push_back(mk(OP_BUS, 15'($urandom_range(32767)), 1'b1, v, SEL_IO1));
      repeat ($urandom_range(1, 3))
        plan_q.push_back(mk(OP_BUS, 15'($urandom_range(32767)), 1'b0,
                            8'($urandom_range(255)), window_sel()));
    end else if (k < 75) begin
      sel = window_sel();
      if ($urandom_range(9) == 0) sel = sel | SEL_BTN;
      plan_q.push_back(mk(OP_BUS, 15'($urandom_range(32767)), $urandom_range(9) < 3,
                          8'($urandom_range(255)), sel));
    end else if (k < 80) begin
      plan_q.push_back(mk($urandom_range(1) ? OP_LOAD_ROM : OP_LOAD_KERNEL,
                          15'($urandom_range(32767)), 1'b0, 8'($urandom_range(255)),
                          6'b0));
    end else if (k < 83) begin
      plan_q.push_back(mk(OP_RESET, 15'($urandom_range(32767)), 1'($urandom_range(1)),
                          8'($urandom_range(255)), 6'($urandom_range(63))));
    end else begin
      plan_q.push_back(item_t'(30'($urandom())));
    end
  endtask

  task automatic run_random(int n);
    int stop;
    stop = n_sent + n;
    while (n_sent < stop) begin
      if (plan_q.size() == 0) plan_more();
      issue(plan_q.pop_front(), 1'b0, '0);
    end
  endtask

  initial begin
    // Mirror the reset state
    cart          = '0;
    cart.enabled  = 1'b1;
    cart.game     = 1'b1;
    cart.nmi      = 1'b1;
    set_ram_upper = 1'b0;
    set_kernel    = 1'b0;
    set_debounce  = DEBOUNCE_INIT;
    foreach (ram_mem[i]) ram_mem[i] = RAM_FILL;

    repeat (11) @(posedge clk);
    rst      <= 1'b0;
    snd_idle = 31;
    rcv_idle = 49;
    set_regs(1'b0, 1'b0, 20'd3);

    // Directed: loads, window reads, control writes, freeze, disable and reset
    dir_rows.push_back({mk(OP_LOAD_ROM, 15'h0000, 1'b0, 8'h5A, 6'b0), 1'b1, QUIET_LINES});
    dir_rows.push_back({mk(OP_LOAD_ROM, 15'h7FFF, 1'b1, 8'hA5, 6'b0), 1'b1, QUIET_LINES});
    dir_rows.push_back({mk(OP_LOAD_ROM, 15'h1F00, 1'b0, 8'h11, SEL_ROML), 1'b1,
                        QUIET_LINES});
    dir_rows.push_back({mk(OP_LOAD_KERNEL, 15'h7FFF, 1'b0, 8'hC3, 6'h3F), 1'b1,
                        QUIET_LINES});
    dir_rows.push_back({mk(OP_BUS, 15'h6000, 1'b0, 8'h00, SEL_ROML), 1'b1,
                        {1'b1, 8'h5A, 1'b1, 1'b0, 1'b1}});
    dir_rows.push_back({mk(OP_BUS, 15'h0000, 1'b0, 8'h00, SEL_IO1), 1'b1,
                        {1'b1, 8'h00, 1'b1, 1'b0, 1'b1}});
    dir_rows.push_back({mk(OP_BUS, 15'h0000, 1'b0, 8'h00, SEL_IO2), 1'b1,
                        {1'b1, 8'h11, 1'b1, 1'b0, 1'b1}});
    dir_rows.push_back({mk(OP_BUS, 15'h0000, 1'b1, 8'h1B, SEL_IO1), 1'b0, 12'h000});
    dir_rows.push_back({mk(OP_BUS, 15'h1FFF, 1'b0, 8'h00, SEL_ROMH), 1'b0, 12'h000});
    dir_rows.push_back({mk(OP_BUS, 15'h0000, 1'b1, 8'h60, SEL_IO1), 1'b0, 12'h000});
    dir_rows.push_back({mk(OP_BUS, 15'h0123, 1'b0, 8'h00, SEL_ROML), 1'b0, 12'h000});
    dir_rows.push_back({mk(OP_BUS, 15'h1FFF, 1'b1, 8'hFF, SEL_ROML), 1'b0, 12'h000});
    dir_rows.push_back({mk(OP_BUS, 15'h00FF, 1'b0, 8'h00, SEL_IO2), 1'b0, 12'h000});
    dir_rows.push_back({mk(OP_BUS, 15'h0000, 1'b0, 8'h00, SEL_BTN), 1'b0, 12'h000});
    repeat (4)
      dir_rows.push_back({mk(OP_BUS, 15'h2222, 1'b1, 8'h00, 6'b0), 1'b0, 12'h000});
    dir_rows.push_back({mk(OP_RESET, 15'h7FFF, 1'b1, 8'hFF, 6'h3F), 1'b1, QUIET_LINES});
    dir_rows.push_back({mk(OP_BUS, 15'h0000, 1'b1, 8'h04, SEL_IO1), 1'b0, 12'h000});
    dir_rows.push_back({mk(OP_BUS, 15'h0000, 1'b0, 8'h00, SEL_ROML), 1'b0, 12'h000});
    dir_rows.push_back({mk(OP_BUS, 15'h7FFF, 1'b1, 8'hFF, 6'h3F), 1'b0, 12'h000});
    dir_rows.push_back({mk(OP_RESET, 15'h0000, 1'b0, 8'h00, 6'b0), 1'b1,
                        {1'b0, 8'h00, 1'b1, 1'b0, 1'b0}});
    dir_rows.push_back({mk(OP_BUS, 15'h0000, 1'b1, 8'hFF, SEL_IO1), 1'b0, 12'h000});
    dir_rows.push_back({mk(OP_RESET, 15'h0000, 1'b0, 8'h00, 6'b0), 1'b1, QUIET_LINES});
    foreach (dir_rows[i]) issue(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

    run_random(300);
    wait_quiet();

    // Variant RAM mapping, kernel served, zero debounce; sender idles more
    snd_idle = 49;
    rcv_idle = 31;
    set_regs(1'b1, 1'b1, 20'd0);
    run_random(150);
    wait_quiet();
    run_random(150);
    wait_quiet();

    // Full-rate stretches at the largest debounce and at a debounce of one
    snd_idle = 0;
    rcv_idle = 0;
    set_regs(1'b1, 1'b0, 20'hFFFFF);
    run_random(175);
    wait_quiet();
    set_regs(1'b0, 1'b1, 20'd1);
    run_random(175);
    wait_quiet();

    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/fcbm_pkg.sv
hw/rtl/fcbm_ram.sv
hw/rtl/fcbm_ctrl.sv
hw/rtl/freezer_cartridge_bus_mapper.sv
dv/tb_freezer_cartridge_bus_mapper.sv
